[rtl/core/sapd_pkg.sv]
`timescale 1ns / 1ps

package sapd_pkg;

   // Field widths
   localparam int ANGLE_IN_W  = 10;
   localparam int ANGLE_W     = 8;
   localparam int PULSE_W     = 16;
   localparam int FREQ_W      = 10;
   localparam int RES_W       = 5;
   localparam int DUTY_W      = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_PULSE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_PULSE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FREQ      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_RES       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ENABLE    = 3'd4;

   // Command kinds
   localparam logic KIND_ABSOLUTE = 1'b0;
   localparam logic KIND_RELATIVE = 1'b1;

   // Register reset values
   localparam logic [PULSE_W-1:0] MIN_PULSE_RESET = 16'd500;
   localparam logic [PULSE_W-1:0] MAX_PULSE_RESET = 16'd2500;
   localparam logic [FREQ_W-1:0]  FREQ_RESET      = 10'd50;
   localparam logic [RES_W-1:0]   RES_RESET       = 5'd12;
   localparam logic               ENABLE_RESET    = 1'b1;
   localparam logic [ANGLE_W-1:0] ANGLE_RESET     = 8'd90;
   localparam logic [RES_W-1:0]   MAX_RES         = 5'd16;

   // Serial divider geometry
   localparam int DIV_NUM_W   = 32;
   localparam int DIV_DEN_W   = 20;
   localparam int DIV_STEPS_W = 5;
   localparam int US_PER_SECOND = 1000000;
   localparam logic [DIV_DEN_W-1:0] PERIOD_RESET = 20'(US_PER_SECOND / 50);
   localparam logic [DIV_STEPS_W-1:0] PERIOD_STEPS = 5'd20;
   localparam logic [DIV_STEPS_W-1:0] HALF_STEPS   = 5'd16;

   typedef struct packed {
      logic                   start;
      logic [DIV_STEPS_W-1:0] steps;
      logic [DIV_DEN_W-1:0]   rem_init;
      logic [DIV_NUM_W-1:0]   num_init;
      logic [DIV_DEN_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_DEN_W-1:0] quotient;
   } div_rsp_type;

endpackage

[rtl/core/sapd_if.sv]
`timescale 1ns / 1ps

interface sapd_req_if;
   logic                             valid;
   logic                             ready;
   logic                             req_type;
   logic [sapd_pkg::ANGLE_IN_W-1:0]  angle_value;
   logic                             move_forward;

   modport source (output valid, output req_type, output angle_value, output move_forward,
                   input ready);
   modport sink (input valid, input req_type, input angle_value, input move_forward,
                 output ready);
endinterface

interface sapd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sapd_pkg::DUTY_W-1:0]   duty_count;
   logic [sapd_pkg::ANGLE_W-1:0]  applied_angle;
   logic                          status;

   modport source (output valid, output duty_count, output applied_angle, output status,
                   input ready);
   modport sink (input valid, input duty_count, input applied_angle, input status,
                 output ready);
endinterface

[rtl/core/sapd_serial_div.sv]
`timescale 1ns / 1ps

module sapd_serial_div (
   input  logic                  clock,
   input  logic                  reset,
   input  sapd_pkg::div_req_type div_req,
   output sapd_pkg::div_rsp_type div_rsp
);

   logic [sapd_pkg::DIV_DEN_W-1:0]   rem_ff;
   logic [sapd_pkg::DIV_NUM_W-1:0]   num_ff;
   logic [sapd_pkg::DIV_DEN_W-1:0]   den_ff;
   logic [sapd_pkg::DIV_STEPS_W-1:0] cnt_ff;
   logic                             busy_ff;
   logic                             done_ff;

   logic [sapd_pkg::DIV_DEN_W:0]     shifted;
   logic                             fits;
   logic [sapd_pkg::DIV_DEN_W:0]     diff;

   // One restoring step: shift in next dividend bit, try subtract
   always_comb begin
      shifted = {rem_ff, num_ff[sapd_pkg::DIV_NUM_W-1]};
      fits    = shifted >= {1'b0, den_ff};
      diff    = shifted - {1'b0, den_ff};
   end

   // Load on start, then retire one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (div_req.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= div_req.steps;
         rem_ff  <= div_req.rem_init;
         num_ff  <= div_req.num_init;
         den_ff  <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff  <= fits ? diff[sapd_pkg::DIV_DEN_W-1:0] : shifted[sapd_pkg::DIV_DEN_W-1:0];
         num_ff  <= {num_ff[sapd_pkg::DIV_NUM_W-2:0], fits};
         cnt_ff  <= cnt_ff - 1'b1;
         busy_ff <= (cnt_ff != sapd_pkg::DIV_STEPS_W'(1));
         done_ff <= (cnt_ff == sapd_pkg::DIV_STEPS_W'(1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = num_ff[sapd_pkg::DIV_DEN_W-1:0];

`ifndef NO_ASSERTIONS
   a_no_start_while_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff) else $error("divider restarted while busy");
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < den_ff) else $error("partial remainder not below divisor");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without a run");
`endif

endmodule

[rtl/core/servo_angle_to_pwm_duty.sv]
// Sequencing: up to 8 multiply steps (bit length of the angle) and two 16-step divider
// passes from transaction accept to result valid; a saturated duty skips the second pass.
// A disabled command skips all of them. One transaction at a time: the next is accepted
// once the result is registered and the state is idle again, unless a period recompute is pending.
// A pwm_frequency_hz write holds off input while the period is recomputed.
// Reset (synchronous) restores the register defaults, angle 90 and a 20000 us period.
`timescale 1ns / 1ps

module servo_angle_to_pwm_duty #(
   parameter int TRAVEL_DEG = 180
) (
   input  logic                              clock,
   input  logic                              reset,
   sapd_req_if.sink                          req_chan,
   sapd_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_en,
   input  logic [sapd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sapd_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   localparam logic [sapd_pkg::ANGLE_IN_W-1:0] ANGLE_LIMIT_W = sapd_pkg::ANGLE_IN_W'(TRAVEL_DEG);
   localparam logic [sapd_pkg::ANGLE_W-1:0]    ANGLE_LIMIT   = sapd_pkg::ANGLE_W'(TRAVEL_DEG);
   localparam int PROD_W = sapd_pkg::PULSE_W + sapd_pkg::ANGLE_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PERIOD, ST_MUL, ST_DIV_ANGLE, ST_SCALE, ST_CHECK, ST_DIV_DUTY, ST_FINISH
   } state_type;

   // Configuration registers
   logic [sapd_pkg::PULSE_W-1:0] min_pulse_ff;
   logic [sapd_pkg::PULSE_W-1:0] max_pulse_ff;
   logic [sapd_pkg::FREQ_W-1:0]  freq_ff;
   logic [sapd_pkg::RES_W-1:0]   res_ff;
   logic                         enable_ff;

   // Control and datapath registers
   state_type                      state_ff;
   logic                           period_pend_ff;
   logic [sapd_pkg::DIV_DEN_W-1:0] period_ff;
   logic [sapd_pkg::ANGLE_W-1:0]   cur_angle_ff;
   logic [PROD_W-1:0]              mul_a_ff;
   logic [sapd_pkg::ANGLE_W-1:0]   mul_b_ff;
   logic [PROD_W-1:0]              acc_ff;
   logic [sapd_pkg::PULSE_W-1:0]   pulse_ff;
   logic [sapd_pkg::DIV_NUM_W-1:0] dividend_ff;
   logic [sapd_pkg::DUTY_W-1:0]    full_ff;
   logic [sapd_pkg::DUTY_W-1:0]    duty_ff;
   logic                           status_ff;
   sapd_pkg::div_req_type          div_req_ff;
   sapd_pkg::div_rsp_type          div_rsp;

   logic                           rsp_valid_ff;
   logic [sapd_pkg::DUTY_W-1:0]    rsp_duty_ff;
   logic [sapd_pkg::ANGLE_W-1:0]   rsp_angle_ff;
   logic                           rsp_status_ff;

   logic                           req_fire;
   logic [sapd_pkg::ANGLE_IN_W-1:0] delta;
   logic [sapd_pkg::ANGLE_IN_W-1:0] cur_wide;
   logic [sapd_pkg::ANGLE_IN_W-1:0] target_wide;
   logic [sapd_pkg::ANGLE_W-1:0]    target;
   logic [sapd_pkg::PULSE_W-1:0]    span;
   logic [sapd_pkg::RES_W-1:0]      res_eff;
   logic [sapd_pkg::DUTY_W:0]       full_wide;
   logic [sapd_pkg::FREQ_W-1:0]     freq_eff;
   logic [sapd_pkg::DUTY_W-1:0]     quot16;
   logic                            duty_sat;
   logic                            div_start_in;

   assign req_chan.ready = (state_ff == ST_IDLE) && !period_pend_ff;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // Resolve the target angle of a command
   always_comb begin
      delta    = {1'b0, req_chan.angle_value[sapd_pkg::ANGLE_IN_W-1:1]};
      cur_wide = sapd_pkg::ANGLE_IN_W'(cur_angle_ff);
      if (req_chan.req_type == sapd_pkg::KIND_ABSOLUTE) begin
         target_wide = req_chan.angle_value;
      end else if (req_chan.move_forward) begin
         target_wide = cur_wide + delta;
      end else begin
         target_wide = (delta > cur_wide) ? '0 : cur_wide - delta;
      end
      target = (target_wide > ANGLE_LIMIT_W) ? ANGLE_LIMIT : target_wide[sapd_pkg::ANGLE_W-1:0];
   end

   // Derived configuration terms
   always_comb begin
      span      = (max_pulse_ff > min_pulse_ff) ? max_pulse_ff - min_pulse_ff : '0;
      res_eff   = (res_ff > sapd_pkg::MAX_RES) ? sapd_pkg::MAX_RES : res_ff;
      full_wide = (sapd_pkg::DUTY_W+1)'(1) << res_eff;
      full_wide = full_wide - (sapd_pkg::DUTY_W+1)'(1);
      freq_eff  = (freq_ff == '0) ? sapd_pkg::FREQ_W'(1) : freq_ff;
      quot16    = div_rsp.quotient[sapd_pkg::DUTY_W-1:0];
   end

   // Launch the divider; a quotient of 2^16 or more saturates without a run
   always_comb begin
      duty_sat     = {4'b0, dividend_ff} >= {period_ff, 16'b0};
      div_start_in = ((state_ff == ST_IDLE) && period_pend_ff) ||
                     ((state_ff == ST_MUL) && (mul_b_ff == '0)) ||
                     ((state_ff == ST_CHECK) && !duty_sat);
   end

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_pulse_ff <= sapd_pkg::MIN_PULSE_RESET;
         max_pulse_ff <= sapd_pkg::MAX_PULSE_RESET;
         freq_ff      <= sapd_pkg::FREQ_RESET;
         res_ff       <= sapd_pkg::RES_RESET;
         enable_ff    <= sapd_pkg::ENABLE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            sapd_pkg::REG_MIN_PULSE: min_pulse_ff <= csr_write_data;
            sapd_pkg::REG_MAX_PULSE: max_pulse_ff <= csr_write_data;
            sapd_pkg::REG_FREQ:      freq_ff <= csr_write_data[sapd_pkg::FREQ_W-1:0];
            sapd_pkg::REG_RES:       res_ff <= csr_write_data[sapd_pkg::RES_W-1:0];
            sapd_pkg::REG_ENABLE:    enable_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Sequence one command through multiply, divide and scale, and recompute the period
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         period_pend_ff <= 1'b0;
         period_ff      <= sapd_pkg::PERIOD_RESET;
         cur_angle_ff   <= sapd_pkg::ANGLE_RESET;
         rsp_valid_ff   <= 1'b0;
         div_req_ff     <= '0;
      end else begin
         div_req_ff.start <= div_start_in;
         if (rsp_valid_ff && rsp_chan.ready && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_en && csr_index == sapd_pkg::REG_FREQ) begin
            period_pend_ff <= 1'b1;
         end
         case (state_ff)
            ST_IDLE: begin
               if (period_pend_ff) begin
                  if (!(csr_write_en && csr_index == sapd_pkg::REG_FREQ)) begin
                     period_pend_ff <= 1'b0;
                  end
                  div_req_ff.steps    <= sapd_pkg::PERIOD_STEPS;
                  div_req_ff.rem_init <= '0;
                  div_req_ff.num_init <= {sapd_pkg::DIV_DEN_W'(sapd_pkg::US_PER_SECOND),
                                          (sapd_pkg::DIV_NUM_W-sapd_pkg::DIV_DEN_W)'(0)};
                  div_req_ff.divisor  <= sapd_pkg::DIV_DEN_W'(freq_eff);
                  state_ff <= ST_PERIOD;
               end else if (req_fire) begin
                  if (!enable_ff) begin
                     duty_ff   <= '0;
                     status_ff <= 1'b1;
                     state_ff  <= ST_FINISH;
                  end else begin
                     cur_angle_ff <= target;
                     mul_a_ff     <= PROD_W'(span);
                     mul_b_ff     <= target;
                     acc_ff       <= '0;
                     status_ff    <= 1'b0;
                     state_ff     <= ST_MUL;
                  end
               end
            end
            ST_PERIOD: begin
               if (div_rsp.done) begin
                  period_ff <= div_rsp.quotient;
                  state_ff  <= ST_IDLE;
               end
            end
            ST_MUL: begin
               // Shift-add one multiplier bit per cycle, stop when none remain
               if (mul_b_ff == '0) begin
                  div_req_ff.steps    <= sapd_pkg::HALF_STEPS;
                  div_req_ff.rem_init <= sapd_pkg::DIV_DEN_W'(acc_ff[PROD_W-1:sapd_pkg::DUTY_W]);
                  div_req_ff.num_init <= {acc_ff[sapd_pkg::DUTY_W-1:0],
                                          (sapd_pkg::DIV_NUM_W-sapd_pkg::DUTY_W)'(0)};
                  div_req_ff.divisor  <= sapd_pkg::DIV_DEN_W'(TRAVEL_DEG);
                  state_ff <= ST_DIV_ANGLE;
               end else begin
                  if (mul_b_ff[0]) begin
                     acc_ff <= acc_ff + mul_a_ff;
                  end
                  mul_a_ff <= {mul_a_ff[PROD_W-2:0], 1'b0};
                  mul_b_ff <= {1'b0, mul_b_ff[sapd_pkg::ANGLE_W-1:1]};
               end
            end
            ST_DIV_ANGLE: begin
               if (div_rsp.done) begin
                  pulse_ff <= min_pulse_ff + quot16;
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               // pulse * (2^res - 1) as a shift and a subtract
               dividend_ff <= (sapd_pkg::DIV_NUM_W'(pulse_ff) << res_eff)
                              - sapd_pkg::DIV_NUM_W'(pulse_ff);
               full_ff     <= full_wide[sapd_pkg::DUTY_W-1:0];
               state_ff    <= ST_CHECK;
            end
            ST_CHECK: begin
               // Quotient of 2^16 or more saturates; otherwise 16 steps suffice
               if (duty_sat) begin
                  duty_ff  <= full_ff;
                  state_ff <= ST_FINISH;
               end else begin
                  div_req_ff.steps    <= sapd_pkg::HALF_STEPS;
                  div_req_ff.rem_init <=
                     sapd_pkg::DIV_DEN_W'(dividend_ff[sapd_pkg::DIV_NUM_W-1:sapd_pkg::DUTY_W]);
                  div_req_ff.num_init <= {dividend_ff[sapd_pkg::DUTY_W-1:0],
                                          (sapd_pkg::DIV_NUM_W-sapd_pkg::DUTY_W)'(0)};
                  div_req_ff.divisor  <= period_ff;
                  state_ff <= ST_DIV_DUTY;
               end
            end
            ST_DIV_DUTY: begin
               if (div_rsp.done) begin
                  duty_ff  <= (quot16 > full_ff) ? full_ff : quot16;
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               // Hand the result to the output register once it is free
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_duty_ff   <= duty_ff;
                  rsp_angle_ff  <= cur_angle_ff;
                  rsp_status_ff <= status_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   sapd_serial_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_rsp (div_rsp)
   );

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.duty_count    = rsp_duty_ff;
   assign rsp_chan.applied_angle = rsp_angle_ff;
   assign rsp_chan.status        = rsp_status_ff;

`ifndef NO_ASSERTIONS
   a_disabled_duty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff |-> rsp_duty_ff == '0)
      else $error("disabled result with nonzero duty");
   a_angle_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_status_ff |-> rsp_angle_ff <= ANGLE_LIMIT)
      else $error("applied angle beyond limit");
   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_PERIOD || state_ff == ST_DIV_ANGLE ||
                       state_ff == ST_DIV_DUTY)
      else $error("divider result with no consumer");
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("accepted transaction not processed");
`endif

endmodule

[tb/sv/tb_servo_angle_to_pwm_duty.sv]
`timescale 1ns / 1ps

module tb_servo_angle_to_pwm_duty;

   localparam int TRAVEL_DEG         = 180;
   localparam int HALF_PERIOD_NS     = 10;
   localparam int RESET_CYCLES       = 4;
   localparam int RUN_LIMIT_NS       = 20_000_000;
   localparam int NUM_PHASES         = 16;
   localparam int ITEMS_PER_PHASE    = 78;
   localparam int FREQ_SETTLE_CYCLES = 30;
   localparam int TAIL_CYCLES        = 60;
   localparam int HOLD_OFF_CYCLES    = 400;
   localparam int PRESSURE_PHASE     = 5;

   typedef struct packed {
      logic [sapd_pkg::DUTY_W-1:0]  duty;
      logic [sapd_pkg::ANGLE_W-1:0] angle;
      logic                         status;
   } servo_result_type;

   typedef enum logic {ROW_COMMAND, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type                       row_kind;
      logic [sapd_pkg::CSR_INDEX_W-1:0]   reg_index;
      logic [sapd_pkg::CSR_DATA_W-1:0]    reg_value;
      logic                               kind;
      logic [sapd_pkg::ANGLE_IN_W-1:0]    amount;
      logic                               forward;
      bit                                 typed;
      servo_result_type                   typed_result;
   } directed_row_type;

   logic clock;
   logic reset;
   logic                             csr_write_en;
   logic [sapd_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [sapd_pkg::CSR_DATA_W-1:0]  csr_write_data;

   sapd_req_if req_bus ();
   sapd_rsp_if rsp_bus ();

   servo_angle_to_pwm_duty #(
      .TRAVEL_DEG(TRAVEL_DEG)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // Mirror of the register file and the held angle
   logic [sapd_pkg::PULSE_W-1:0] cfg_min_pulse;
   logic [sapd_pkg::PULSE_W-1:0] cfg_max_pulse;
   logic [sapd_pkg::FREQ_W-1:0]  cfg_freq;
   logic [sapd_pkg::RES_W-1:0]   cfg_res;
   logic                         cfg_enable;
   logic [sapd_pkg::ANGLE_W-1:0] held_angle;

   servo_result_type pending_results[$];
   directed_row_type directed_rows[$];
   int mismatch_count;
   int sender_idle_pct;
   int receiver_stall_pct;
   int hold_off_requests;

   // Clock
   always begin
      clock = 1'b1;
      #HALF_PERIOD_NS;
      clock = 1'b0;
      #HALF_PERIOD_NS;
   end

   // Map an angle to the saturated PWM compare count
   function automatic logic [sapd_pkg::DUTY_W-1:0] duty_for_angle(
      input logic [sapd_pkg::ANGLE_W-1:0] ang);
      longint unsigned span;
      longint unsigned pulse;
      longint unsigned full;
      longint unsigned period;
      longint unsigned duty;
      int unsigned     res;
      int unsigned     freq;
      span = (cfg_max_pulse > cfg_min_pulse) ?
             64'(cfg_max_pulse) - 64'(cfg_min_pulse) : 64'd0;
      pulse = 64'(cfg_min_pulse) + span * 64'(ang) / 64'(TRAVEL_DEG);
      res = (cfg_res > sapd_pkg::MAX_RES) ? 32'(sapd_pkg::MAX_RES) : 32'(cfg_res);
      full = (64'd1 << res) - 64'd1;
      freq = (cfg_freq == '0) ? 32'd1 : 32'(cfg_freq);
      period = 64'(sapd_pkg::US_PER_SECOND) / 64'(freq);
      duty = pulse * full / period;
      if (duty > full) begin
         duty = full;
      end
      return duty[sapd_pkg::DUTY_W-1:0];
   endfunction

   // Apply one command to the held angle and return its result
   function automatic servo_result_type next_servo_result(
      input logic kind,
      input logic [sapd_pkg::ANGLE_IN_W-1:0] amount,
      input logic forward);
      servo_result_type res;
      int unsigned      target;
      int unsigned      delta;
      if (!cfg_enable) begin
         res.duty = '0;
         res.angle = held_angle;
         res.status = 1'b1;
         return res;
      end
      if (kind == sapd_pkg::KIND_ABSOLUTE) begin
         target = 32'(amount);
      end else begin
         delta = 32'(amount >> 1);
         if (forward) begin
            target = 32'(held_angle) + delta;
         end else begin
            target = (delta > 32'(held_angle)) ? 32'd0 : 32'(held_angle) - delta;
         end
      end
      if (target > 32'(TRAVEL_DEG)) begin
         target = 32'(TRAVEL_DEG);
      end
      held_angle = target[sapd_pkg::ANGLE_W-1:0];
      res.duty = duty_for_angle(held_angle);
      res.angle = held_angle;
      res.status = 1'b0;
      return res;
   endfunction

   // Offer one command, hold it until accepted, then queue its expected result
   task automatic send_command(input logic kind, input logic [sapd_pkg::ANGLE_IN_W-1:0] amount,
                               input logic forward, input bit typed,
                               input servo_result_type typed_result);
      servo_result_type predicted;
      while (int'($urandom_range(99)) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.angle_value <= amount;
      req_bus.move_forward <= forward;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      predicted = next_servo_result(kind, amount, forward);
      pending_results.push_back(typed ? typed_result : predicted);
   endtask

   // Drop valid and wait until every expected result has come back
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Write one register; a frequency write starts a period recompute
   task automatic write_register(input logic [sapd_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [sapd_pkg::CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      case (idx)
         sapd_pkg::REG_MIN_PULSE: cfg_min_pulse = value;
         sapd_pkg::REG_MAX_PULSE: cfg_max_pulse = value;
         sapd_pkg::REG_FREQ:      cfg_freq = value[sapd_pkg::FREQ_W-1:0];
         sapd_pkg::REG_RES:       cfg_res = value[sapd_pkg::RES_W-1:0];
         sapd_pkg::REG_ENABLE:    cfg_enable = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
      if (idx == sapd_pkg::REG_FREQ) begin
         repeat (FREQ_SETTLE_CYCLES) @(negedge clock);
      end
   endtask

   task automatic add_command(input logic kind, input logic [sapd_pkg::ANGLE_IN_W-1:0] amount,
                              input logic forward, input bit typed,
                              input logic [sapd_pkg::DUTY_W-1:0] duty,
                              input logic [sapd_pkg::ANGLE_W-1:0] ang,
                              input logic status);
      directed_row_type row;
      row.row_kind = ROW_COMMAND;
      row.reg_index = '0;
      row.reg_value = '0;
      row.kind = kind;
      row.amount = amount;
      row.forward = forward;
      row.typed = typed;
      row.typed_result.duty = duty;
      row.typed_result.angle = ang;
      row.typed_result.status = status;
      directed_rows.push_back(row);
   endtask

   task automatic add_write(input logic [sapd_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [sapd_pkg::CSR_DATA_W-1:0] value);
      directed_row_type row;
      row.row_kind = ROW_WRITE;
      row.reg_index = idx;
      row.reg_value = value;
      row.kind = sapd_pkg::KIND_ABSOLUTE;
      row.amount = '0;
      row.forward = 1'b0;
      row.typed = 1'b0;
      row.typed_result = '0;
      directed_rows.push_back(row);
   endtask

   // Drive ready: random stalls, plus a long hold-off on request
   initial begin
      int hold_left;
      int hold_served;
      hold_left = 0;
      hold_served = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_requests != hold_served) begin
            hold_served = hold_off_requests;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= (int'($urandom_range(99)) >= receiver_stall_pct);
         end
      end
   end

   // Check each result transaction against the oldest expectation
   always @(posedge clock) begin
      servo_result_type got;
      servo_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.duty = rsp_bus.duty_count;
         got.angle = rsp_bus.applied_angle;
         got.status = rsp_bus.status;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result duty=%0d angle=%0d status=%0d",
                     $time, got.duty, got.angle, got.status);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               $display("%0t: mismatch expected duty=%0d angle=%0d status=%0d,",
                        $time, want.duty, want.angle, want.status,
                        " got duty=%0d angle=%0d status=%0d",
                        got.duty, got.angle, got.status);
            end
         end
      end
   end

   // Hard stop
   initial begin
      #RUN_LIMIT_NS;
      $display("FAIL servo_angle_to_pwm_duty");
      $finish;
   end

   // Stimulus
   initial begin
      directed_row_type row;
      int            pick;
      int            lo;
      logic [sapd_pkg::CSR_DATA_W-1:0] min_val;
      logic [sapd_pkg::CSR_DATA_W-1:0] max_val;
      logic [sapd_pkg::CSR_DATA_W-1:0] freq_val;
      logic [sapd_pkg::CSR_DATA_W-1:0] res_val;
      logic [sapd_pkg::CSR_DATA_W-1:0] en_val;
      logic                            kind;
      logic [sapd_pkg::ANGLE_IN_W-1:0] amount;

      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.req_type = sapd_pkg::KIND_ABSOLUTE;
      req_bus.angle_value = '0;
      req_bus.move_forward = 1'b0;
      mismatch_count = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_off_requests = 0;
      cfg_min_pulse = sapd_pkg::MIN_PULSE_RESET;
      cfg_max_pulse = sapd_pkg::MAX_PULSE_RESET;
      cfg_freq = sapd_pkg::FREQ_RESET;
      cfg_res = sapd_pkg::RES_RESET;
      cfg_enable = sapd_pkg::ENABLE_RESET;
      held_angle = sapd_pkg::ANGLE_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset defaults, clamps at both ends, disable, odd register values
      add_command(sapd_pkg::KIND_ABSOLUTE, 10'd90, 1'b0, 1'b1, 16'd307, 8'd90, 1'b0);
      add_command(sapd_pkg::KIND_ABSOLUTE, 10'd0, 1'b0, 1'b1, 16'd102, 8'd0, 1'b0);
      add_command(sapd_pkg::KIND_ABSOLUTE, 10'd180, 1'b0, 1'b1, 16'd511, 8'd180, 1'b0);
      add_command(sapd_pkg::KIND_ABSOLUTE, 10'd1023, 1'b0, 1'b1, 16'd511, 8'd180, 1'b0);
      add_command(sapd_pkg::KIND_RELATIVE, 10'd1023, 1'b1, 1'b1, 16'd511, 8'd180, 1'b0);
      add_command(sapd_pkg::KIND_RELATIVE, 10'd1023, 1'b0, 1'b1, 16'd102, 8'd0, 1'b0);
      add_command(sapd_pkg::KIND_RELATIVE, 10'd3, 1'b0, 1'b0, '0, '0, 1'b0);
      add_command(sapd_pkg::KIND_RELATIVE, 10'd3, 1'b1, 1'b0, '0, '0, 1'b0);
      add_command(sapd_pkg::KIND_RELATIVE, 10'd181, 1'b1, 1'b0, '0, '0, 1'b0);
      add_command(sapd_pkg::KIND_RELATIVE, 10'd1, 1'b0, 1'b0, '0, '0, 1'b0);
      add_command(sapd_pkg::KIND_ABSOLUTE, 10'd181, 1'b0, 1'b1, 16'd511, 8'd180, 1'b0);
      add_write(sapd_pkg::REG_ENABLE, 16'd0);
      add_command(sapd_pkg::KIND_ABSOLUTE, 10'd45, 1'b0, 1'b1, 16'd0, 8'd180, 1'b1);
      add_command(sapd_pkg::KIND_RELATIVE, 10'd1023, 1'b0, 1'b1, 16'd0, 8'd180, 1'b1);
      add_write(sapd_pkg::REG_ENABLE, 16'd1);
      add_command(sapd_pkg::KIND_ABSOLUTE, 10'd45, 1'b0, 1'b0, '0, '0, 1'b0);
      // Reversed pulse range pins the pulse at the minimum
      add_write(sapd_pkg::REG_MAX_PULSE, 16'd100);
      add_command(sapd_pkg::KIND_ABSOLUTE, 10'd120, 1'b0, 1'b1, 16'd102, 8'd120, 1'b0);
      add_write(sapd_pkg::REG_RES, 16'd0);
      add_command(sapd_pkg::KIND_ABSOLUTE, 10'd60, 1'b0, 1'b1, 16'd0, 8'd60, 1'b0);
      add_write(sapd_pkg::REG_RES, 16'd31);
      add_command(sapd_pkg::KIND_ABSOLUTE, 10'd60, 1'b0, 1'b0, '0, '0, 1'b0);
      add_write(sapd_pkg::REG_MIN_PULSE, 16'd0);
      add_write(sapd_pkg::REG_MAX_PULSE, 16'd65535);
      add_write(sapd_pkg::REG_FREQ, 16'd1000);
      add_command(sapd_pkg::KIND_ABSOLUTE, 10'd180, 1'b0, 1'b1, 16'd65535, 8'd180, 1'b0);
      add_command(sapd_pkg::KIND_ABSOLUTE, 10'd0, 1'b0, 1'b1, 16'd0, 8'd0, 1'b0);
      add_write(sapd_pkg::REG_FREQ, 16'd0);
      add_command(sapd_pkg::KIND_ABSOLUTE, 10'd90, 1'b0, 1'b0, '0, '0, 1'b0);
      add_write(sapd_pkg::REG_FREQ, 16'd1023);
      add_command(sapd_pkg::KIND_RELATIVE, 10'd682, 1'b1, 1'b0, '0, '0, 1'b0);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.row_kind == ROW_WRITE) begin
            drain_results();
            write_register(row.reg_index, row.reg_value);
         end else begin
            send_command(row.kind, row.amount, row.forward, row.typed, row.typed_result);
         end
      end

      // Random phases, each with its own register setting and one of four idle patterns
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         drain_results();
         case (phase)
            0: begin
               min_val = sapd_pkg::MIN_PULSE_RESET;
               max_val = sapd_pkg::MAX_PULSE_RESET;
               freq_val = 16'(sapd_pkg::FREQ_RESET);
               res_val = 16'(sapd_pkg::RES_RESET);
               en_val = 16'd1;
            end
            1: begin
               min_val = 16'd0;
               max_val = 16'd65535;
               freq_val = 16'd1000;
               res_val = 16'd16;
               en_val = 16'd1;
            end
            2: begin
               min_val = 16'd65535;
               max_val = 16'd0;
               freq_val = 16'd1;
               res_val = 16'd1;
               en_val = 16'd1;
            end
            3: begin
               min_val = 16'd1000;
               max_val = 16'd2000;
               freq_val = 16'd50;
               res_val = 16'd12;
               en_val = 16'd0;
            end
            default: begin
               if ($urandom_range(3) == 0) begin
                  min_val = 16'($urandom_range(16'hFFFF));
                  max_val = 16'($urandom_range(16'hFFFF));
               end else begin
                  min_val = 16'($urandom_range(3000));
                  max_val = min_val + 16'($urandom_range(3000));
               end
               if ($urandom_range(9) == 0) begin
                  freq_val = 16'($urandom_range(1023));
               end else begin
                  freq_val = 16'($urandom_range(1000, 1));
               end
               if ($urandom_range(7) == 0) begin
                  res_val = 16'($urandom_range(31));
               end else begin
                  res_val = 16'($urandom_range(16, 1));
               end
               en_val = (int'($urandom_range(99)) < 85) ? 16'd1 : 16'd0;
            end
         endcase
         write_register(sapd_pkg::REG_MIN_PULSE, min_val);
         write_register(sapd_pkg::REG_MAX_PULSE, max_val);
         write_register(sapd_pkg::REG_RES, res_val);
         write_register(sapd_pkg::REG_ENABLE, en_val);
         write_register(sapd_pkg::REG_FREQ, freq_val);

         case (phase % 4)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 67;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 67;
            end
            default: begin
               sender_idle_pct = 11;
               receiver_stall_pct = 11;
            end
         endcase

         // Hold the result side off while commands keep coming
         if (phase == PRESSURE_PHASE) begin
            hold_off_requests++;
         end

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            pick = int'($urandom_range(99));
            if (pick < 35) begin
               kind = sapd_pkg::KIND_ABSOLUTE;
               amount = 10'($urandom_range(200));
            end else if (pick < 45) begin
               kind = sapd_pkg::KIND_ABSOLUTE;
               amount = 10'($urandom_range(1023));
            end else if (pick < 85) begin
               kind = sapd_pkg::KIND_RELATIVE;
               lo = int'($urandom_range(1));
               amount = (lo != 0) ? 10'($urandom_range(40)) : 10'($urandom_range(400));
            end else begin
               kind = sapd_pkg::KIND_RELATIVE;
               amount = 10'($urandom_range(1023));
            end
            send_command(kind, amount, 1'($urandom_range(1)), 1'b0, '0);
         end
      end

      // Let everything come back, then a short tail
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("PASS servo_angle_to_pwm_duty");
      end else begin
         $display("FAIL servo_angle_to_pwm_duty");
      end
      $finish;
   end

endmodule
